### design/sha_pkg.sv
package sha_pkg;

    typedef logic [7:0][31:0] word8_t;
    typedef logic [15:0][31:0] window_t;

    typedef struct packed {
        logic push;
        logic load;
        logic round;
    } core_ctrl_t;

    localparam word8_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### design/sha_sched.sv
module sha_sched (
    input  logic                aclk,
    input  sha_pkg::core_ctrl_t ctrl,
    input  logic [7:0]          push_byte,
    output logic [31:0]         w_t
);

    sha_pkg::window_t w_reg;
    sha_pkg::window_t w_next;
    logic [31:0]      w_new;

    // window holds W[t] in the top word and W[t+15] in the bottom word
    assign w_new = sha_pkg::small_sigma1(w_reg[1]) + w_reg[6]
                 + sha_pkg::small_sigma0(w_reg[14]) + w_reg[15];

    always_comb begin
        priority if (ctrl.push) begin
            w_next = 512'({w_reg, push_byte});
        end else if (ctrl.round) begin
            w_next = {w_reg[14:0], w_new};
        end else begin
            w_next = w_reg;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

    assign w_t = w_reg[15];

endmodule

### design/sha_round.sv
module sha_round (
    input  logic                aclk,
    input  sha_pkg::core_ctrl_t ctrl,
    input  logic [31:0]         w_t,
    input  logic [31:0]         k_t,
    input  sha_pkg::word8_t     chain,
    output sha_pkg::word8_t     vars
);

    sha_pkg::word8_t v_reg;
    sha_pkg::word8_t v_next;
    logic [31:0]     ch;
    logic [31:0]     maj;
    logic [31:0]     t1;
    logic [31:0]     t2;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + sha_pkg::big_sigma1(v_reg[4]) + ch + k_t + w_t;
    assign t2  = sha_pkg::big_sigma0(v_reg[0]) + maj;

    always_comb begin
        priority if (ctrl.load) begin
            v_next = chain;
        end else if (ctrl.round) begin
            v_next    = {v_reg[6:0], t1 + t2};
            v_next[4] = v_reg[3] + t1;
        end else begin
            v_next = v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
    end

    assign vars = v_reg;

endmodule

### design/sha256_stream_hasher.sv
// a byte beat is taken while s_ready is high; the 64th byte of a block starts
// compression (64 rounds on the shared round unit, then the chaining add)
// message end: the 0x80 pad byte, zero bytes and the big-endian bit length
// are pushed one by one up to the block end, each full block is compressed,
// then 8 digest beats go out; s_ready stays low until the last beat is taken
// aresetn (synchronous, active low) loads the initial hash and clears counts
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_message_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COMP   = 7'b0000010,
        ST_FINAL  = 7'b0000100,
        ST_PAD80  = 7'b0001000,
        ST_PADZ   = 7'b0010000,
        ST_PADLEN = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [5:0] RND_LAST  = 6'd63;
    localparam logic [2:0] IDX_LAST  = 3'd7;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [5:0]          fill_reg, fill_next;
    logic [63:0]         len_reg, len_next;
    logic [5:0]          rnd_reg, rnd_next;
    logic [2:0]          idx_reg, idx_next;
    sha_pkg::word8_t     chain_reg, chain_next;
    sha_pkg::core_ctrl_t ctrl;
    logic [7:0]          push_byte;
    logic [31:0]         w_t;
    sha_pkg::word8_t     vars;

    sha_sched u_sched (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .push_byte (push_byte),
        .w_t       (w_t)
    );

    sha_round u_round (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .w_t   (w_t),
        .k_t   (sha_pkg::ROUND_K[rnd_reg]),
        .chain (chain_reg),
        .vars  (vars)
    );

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        ctrl       = '0;
        push_byte  = 8'h00;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_byte_present) begin
                        ctrl.push = 1'b1;
                        push_byte = s_data_byte;
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 64'd8;
                        if (fill_reg == FILL_LAST) begin
                            ctrl.load  = 1'b1;
                            state_next = ST_COMP;
                            ret_next   = s_message_end ? ST_PAD80 : ST_IDLE;
                        end else if (s_message_end) begin
                            state_next = ST_PAD80;
                        end
                    end else if (s_message_end) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                ctrl.push  = 1'b1;
                push_byte  = sha_pkg::PAD_BYTE;
                fill_next  = fill_reg + 6'd1;
                state_next = ST_PADZ;
                if (fill_reg == FILL_LAST) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_COMP;
                    ret_next   = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (fill_reg == FILL_LEN) begin
                    state_next = ST_PADLEN;
                end else begin
                    ctrl.push = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST) begin
                        ctrl.load  = 1'b1;
                        state_next = ST_COMP;
                        ret_next   = ST_PADZ;
                    end
                end
            end
            ST_PADLEN: begin
                // length goes out big-endian; shifting leaves it at zero
                ctrl.push = 1'b1;
                push_byte = len_reg[63:56];
                len_next  = len_reg << 8;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_COMP;
                    ret_next   = ST_OUT;
                end
            end
            ST_COMP: begin
                ctrl.round = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == RND_LAST) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                state_next = ret_reg;
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == IDX_LAST) begin
                        chain_next = sha_pkg::INIT_H;
                        len_next   = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            chain_reg <= sha_pkg::INIT_H;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_last_word   = (idx_reg == IDX_LAST);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_rnd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMP) |-> (rnd_reg == 6'd0))
        else $error("round counter off zero outside compression");

    a_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |-> (ctrl.push && fill_reg == FILL_LAST))
        else $error("compression started without a full block");

    a_len_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PADLEN) |-> (fill_reg[5:3] == 3'b111))
        else $error("length bytes outside block tail");

    a_done_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && len_reg == 64'd0
            && fill_reg == 6'd0))
        else $error("state not cleared after digest");

endmodule

### test/sha256_stream_hasher_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] chain_t;
    typedef logic [63:0][7:0] block_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 300;

    localparam chain_t SHA_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_byte_present;
    logic        s_message_end;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    digest_beat_t expected_words [$];
    chain_t       model_chain;
    block_t       model_block;
    int           model_fill;
    logic [63:0]  model_bits;

    int fail_count = 0;
    int cycle_count = 0;
    int hold_request = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    sha256_stream_hasher i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_byte_present (s_byte_present),
        .s_message_end  (s_message_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic chain_t sha_compress(input chain_t h, input block_t blk);
        word_t w [16];
        word_t a, b, c, d, e, f, g, hh;
        word_t t1, t2, s0, s1, wi, w15, w2;
        chain_t r;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (i = 0; i < 64; i++) begin
            if (i < 16) begin
                wi = w[i];
            end else begin
                w15 = w[(i - 15) & 15];
                w2 = w[(i - 2) & 15];
                s0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
                s1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
                wi = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
                w[i & 15] = wi;
            end
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                 ((e & f) ^ (~e & g)) + ROUND_CONST[i] + wi;
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                 ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d;
        r[4] = h[4] + e; r[5] = h[5] + f; r[6] = h[6] + g; r[7] = h[7] + hh;
        return r;
    endfunction

    task automatic sha_model_reset();
        model_chain = SHA_IV;
        model_block = '0;
        model_fill = 0;
        model_bits = '0;
    endtask

    task automatic sha_model_absorb(input logic [7:0] b, input logic present,
                                    input logic close);
        int i;
        digest_beat_t beat;
        if (present) begin
            model_block[model_fill] = b;
            model_bits = model_bits + 64'd8;
            model_fill++;
            if (model_fill == 64) begin
                model_chain = sha_compress(model_chain, model_block);
                model_fill = 0;
            end
        end
        if (close) begin
            model_block[model_fill] = 8'h80;
            for (i = model_fill + 1; i < 64; i++) begin
                model_block[i] = 8'h00;
            end
            if (model_fill >= 56) begin
                model_chain = sha_compress(model_chain, model_block);
                model_block = '0;
            end
            for (i = 0; i < 8; i++) begin
                model_block[56 + i] = model_bits[8 * (7 - i) +: 8];
            end
            model_chain = sha_compress(model_chain, model_block);
            for (i = 0; i < 8; i++) begin
                beat.digest_word = model_chain[i];
                beat.word_index = 3'(i);
                beat.last_word = (i == 7);
                expected_words.insert(expected_words.size(), beat);
            end
            sha_model_reset();
        end
    endtask

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] b, input logic present, input logic close);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_byte_present <= present;
        s_message_end <= close;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sha_model_absorb(b, present, close);
        @(negedge aclk);
    endtask

    // end_style: 0 flag-only beat closes, 1 last byte closes, other random
    task automatic send_message(input int len, input int end_style);
        int k;
        bit close_on_byte;
        logic [7:0] b;
        close_on_byte = (len > 0) && (end_style == 1 ||
                        (end_style > 1 && $urandom_range(0, 1) == 1));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                b = 8'($urandom_range(0, 255));
                send_item(b, 1'b0, 1'b0);
            end
            b = 8'($urandom_range(0, 255));
            send_item(b, 1'b1, close_on_byte && (k == len - 1));
        end
        if (!close_on_byte) begin
            b = 8'($urandom_range(0, 255));
            send_item(b, 1'b0, 1'b1);
        end
    endtask

    task automatic wait_for_digests();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_words.size() != 0) @(negedge aclk);
    endtask

    task automatic test_empty_and_idle();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'ha5, 1'b0, 1'b0);
    endtask

    task automatic test_short_messages();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
    endtask

    // pad lands at the start of the length field, on the last block byte, and after a full block
    task automatic test_padding_boundaries();
        send_message(56, 0);
        send_message(63, 0);
        send_message(64, 1);
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 16) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            len = $urandom_range(0, 6);
            send_message(len, 2);
            sent += len + 1;
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int k;
        gaps_on = 1'b0;
        hold_request = 500;
        for (k = 0; k < 4; k++) begin
            send_message($urandom_range(1, 3), 2);
        end
        gaps_on = 1'b1;
        wait_for_digests();
        send_message(3, 1);
    endtask

    task automatic test_full_rate();
        int k;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (k = 0; k < 3; k++) begin
            send_message($urandom_range(0, 5), 2);
        end
    endtask

    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        digest_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("digest beat with none expected: word %h index %0d",
                       m_digest_word, m_word_index);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_digest_word !== want.digest_word) begin
                    $error("digest_word expected %h actual %h", want.digest_word, m_digest_word);
                    fail_count++;
                end
                if (m_word_index !== want.word_index) begin
                    $error("word_index expected %0d actual %0d", want.word_index, m_word_index);
                    fail_count++;
                end
                if (m_last_word !== want.last_word) begin
                    $error("last_word expected %0d actual %0d", want.last_word, m_last_word);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = 8'h00;
        s_byte_present = 1'b0;
        s_message_end = 1'b0;
        sha_model_reset();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_and_idle();
        test_short_messages();
        test_padding_boundaries();
        test_random_messages();
        test_output_backpressure();
        test_full_rate();

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
